### src/smgr_pkg.sv
// ----------------------------------------------------------------------------
// smgr_pkg
// Shared types and constants for the soft-mute gain ramp.
// ----------------------------------------------------------------------------
package smgr_pkg;

    // Fixed-point layout of the gain
    localparam int GainShift = 23;
    localparam int SlopeBase = 16;
    localparam int ExpBase   = 9;

    localparam int SampleW = 16;
    localparam int GainW   = 32;
    localparam int GainHiW = 16;
    localparam int ProdW   = SampleW + GainHiW;
    localparam int ShiftW  = 5;

    // Register indexes (word address bits [3:2])
    localparam logic [1:0] RegMantissa = 2'd0;
    localparam logic [1:0] RegExponent = 2'd1;
    localparam logic [1:0] RegSlope    = 2'd2;
    localparam logic [1:0] RegMute     = 2'd3;

    // Configuration seen by the datapath and the ramp
    typedef struct packed {
        logic [7:0] mant_setting;
        logic [3:0] exp_setting;
        logic [3:0] slope_setting;
        logic       mute;
    } smgr_cfg_t;

endpackage

### src/soft_mute_gain_ramp_top.sv
// ----------------------------------------------------------------------------
// soft_mute_gain_ramp_top
// Soft-mute gain stage with an exponential gain ramp.
// ----------------------------------------------------------------------------
// One signed 16-bit sample is accepted every cycle unless backpressure holds
// the pipeline; each result passes from a capture register to a result
// register (multiply, shift, saturation in between), with backpressure handled
// stage by stage. Each sample is scaled by the top 16 bits of a smoothed
// 32-bit gain, shifted right by nine plus the exponent register and saturated;
// m_tuser flags saturation. After each sample the gain steps toward the
// mantissa register << 23, or to zero at half the slope setting when muted. The
// gain starts at zero after reset, so output fades in. Registers sit at byte
// addresses 0x0 mantissa, 0x4 exponent, 0x8 slope, 0xC mute; write them only
// while no samples are in flight.
// ----------------------------------------------------------------------------
module soft_mute_gain_ramp_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    output logic [0:0]  m_tuser    // [0] clipped
);
    import smgr_pkg::*;

    smgr_cfg_t   cfg;
    logic [15:0] gain_hi;
    logic        step;

    smgr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smgr_gain u_gain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .gain_hi (gain_hi)
    );

    smgr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .gain_hi  (gain_hi),
        .step     (step),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### src/smgr_cfg.sv
// ----------------------------------------------------------------------------
// smgr_cfg
// APB register file: gain mantissa, gain exponent, slope setting, mute.
// ----------------------------------------------------------------------------
module smgr_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output smgr_pkg::smgr_cfg_t cfg
);
    import smgr_pkg::*;

    smgr_cfg_t cfg_reg;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mant_setting  <= 8'd128;
            cfg_reg.exp_setting   <= 4'd5;
            cfg_reg.slope_setting <= 4'd8;
            cfg_reg.mute          <= 1'b0;
        end else if (wr_en) begin
            case (paddr[3:2])
                RegMantissa: cfg_reg.mant_setting  <= pwdata[7:0];
                RegExponent: cfg_reg.exp_setting   <= pwdata[3:0];
                RegSlope:    cfg_reg.slope_setting <= pwdata[3:0];
                RegMute:     cfg_reg.mute          <= pwdata[0];
                default:     ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        case (paddr[3:2])
            RegMantissa: prdata = {24'd0, cfg_reg.mant_setting};
            RegExponent: prdata = {28'd0, cfg_reg.exp_setting};
            RegSlope:    prdata = {28'd0, cfg_reg.slope_setting};
            RegMute:     prdata = {31'd0, cfg_reg.mute};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

### src/smgr_gain.sv
// ----------------------------------------------------------------------------
// smgr_gain
// Smoothed gain state: first-order ramp toward the target, one step per word.
// ----------------------------------------------------------------------------
module smgr_gain (
    input  logic                aclk,
    input  logic                aresetn,
    input  smgr_pkg::smgr_cfg_t cfg,
    input  logic                step,
    output logic [15:0]         gain_hi
);
    import smgr_pkg::*;

    logic signed [GainW-1:0] gain_reg;
    logic signed [GainW-1:0] gain_next;
    logic signed [GainW:0]   target;
    logic signed [GainW:0]   diff;
    logic signed [GainW:0]   delta;
    logic signed [GainW:0]   sum;
    logic [ShiftW-1:0]       smooth;

    // Pick target and smoothing shift
    always_comb begin
        if (cfg.mute) begin
            target = '0;
            smooth = ShiftW'(SlopeBase) - {2'b00, cfg.slope_setting[3:1]};
        end else begin
            target = $signed({2'b00, cfg.mant_setting, 23'd0});
            smooth = ShiftW'(SlopeBase) - {1'b0, cfg.slope_setting};
        end
        diff      = target - {gain_reg[GainW-1], gain_reg};
        delta     = diff >>> smooth;
        sum       = {gain_reg[GainW-1], gain_reg} + delta;
        gain_next = sum[GainW-1:0];
    end

    // Advance the ramp once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
        end else if (step) begin
            gain_reg <= gain_next;
        end
    end

    assign gain_hi = gain_reg[GainW-1 -: GainHiW];

endmodule

### src/smgr_datapath.sv
// ----------------------------------------------------------------------------
// smgr_datapath
// Two-stage sample path: capture, then multiply, shift and saturate.
// ----------------------------------------------------------------------------
module smgr_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  smgr_pkg::smgr_cfg_t cfg,
    input  logic [15:0]         gain_hi,
    output logic                step,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic [0:0]          m_tuser
);
    import smgr_pkg::*;

    logic                      s1_valid_reg;
    logic signed [SampleW-1:0] s1_sample_reg;
    logic signed [GainHiW-1:0] s1_gain_reg;
    logic                      s2_valid_reg;
    logic [SampleW-1:0]        s2_data_reg;
    logic                      s2_clip_reg;

    logic                      rdy1;
    logic                      rdy2;
    logic [ShiftW-1:0]         shamt;
    logic signed [ProdW-1:0]   prod;
    logic signed [ProdW-1:0]   scaled;
    logic [SampleW-1:0]        sat_data;
    logic                      sat_clip;

    // Each stage moves when its slot is empty or the next one takes it
    assign rdy2     = !s2_valid_reg || m_tready;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;
    assign step     = s_tvalid && rdy1;

    // Capture the sample with the gain in force before this word's update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (rdy1) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            s1_sample_reg <= $signed(s_tdata);
            s1_gain_reg   <= $signed(gain_hi);
        end
    end

    // Multiply, shift by nine plus the exponent, then saturate to 16 bits
    always_comb begin
        prod   = s1_sample_reg * s1_gain_reg;
        shamt  = ShiftW'(ExpBase) + {1'b0, cfg.exp_setting};
        scaled = prod >>> shamt;
        if ((&scaled[ProdW-1:SampleW-1]) || !(|scaled[ProdW-1:SampleW-1])) begin
            sat_data = scaled[SampleW-1:0];
            sat_clip = 1'b0;
        end else if (scaled[ProdW-1]) begin
            sat_data = {1'b1, {(SampleW-1){1'b0}}};
            sat_clip = 1'b1;
        end else begin
            sat_data = {1'b0, {(SampleW-1){1'b1}}};
            sat_clip = 1'b1;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (rdy2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && s1_valid_reg) begin
            s2_data_reg <= sat_data;
            s2_clip_reg <= sat_clip;
        end
    end

    assign m_tvalid   = s2_valid_reg;
    assign m_tdata    = s2_data_reg;
    assign m_tuser[0] = s2_clip_reg;

endmodule

### tb/sv/soft_mute_gain_ramp_top_tb.sv
// ----------------------------------------------------------------------------
// soft_mute_gain_ramp_top_tb
// Self-checking bench for the soft-mute gain stage: streams samples through
// the block under random source and sink stalls, tracks the gain ramp in a
// local model and compares every output word with the expected result.
// ----------------------------------------------------------------------------
module soft_mute_gain_ramp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smgr_pkg::*;

    localparam int ClkPeriod  = 10;
    localparam int ResetLen   = 7;
    localparam int PipeDepth  = 2;
    localparam int IdlePct    = 13;
    localparam int QuietLo    = 600;     // no source or sink idling in this window
    localparam int QuietHi    = 800;
    localparam int HoldAt     = 300;     // sink holds off once this many words are out
    localparam int HoldLen    = 80;
    localparam int PhaseCount = 13;
    localparam int StallLimit = 2000;

    typedef struct packed {
        logic [15:0] sample_out;
        logic        clipped;
    } sample_result_t;

    typedef enum logic {RowSample, RowWrite} row_kind_e;

    typedef struct packed {
        row_kind_e      kind;
        logic [1:0]     reg_idx;
        logic [31:0]    value;      // register value, or the sample in [15:0]
        logic           typed;      // expected result written out below
        sample_result_t typed_res;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;      // [15:0] sample_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [15:0] sample_out
    logic [0:0]  m_tuser;            // [0] clipped

    // Local copy of the gain ramp and its registers
    smgr_cfg_t          model_cfg;
    logic signed [31:0] ramp_gain;

    sample_result_t scaled_q[$];
    stim_row_t      dir_rows[$];

    int n_sent   = 0;
    int n_recv   = 0;
    int n_clip   = 0;
    int n_writes = 0;
    int err_cnt  = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    sample_result_t got_want;

    soft_mute_gain_ramp_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(ClkPeriod / 2) aclk = ~aclk;

    // Scale one sample by the current gain, then step the gain toward its target
    function automatic sample_result_t scale_and_ramp(input logic [15:0] smp);
        sample_result_t res;
        longint         g;
        longint         gain_top;
        longint         scaled;
        longint         target;
        int             smooth_sh;
        g        = ramp_gain;
        gain_top = g >>> 16;
        scaled   = (longint'($signed(smp)) * gain_top) >>> (ExpBase + model_cfg.exp_setting);
        res.clipped = 1'b0;
        if (scaled > 32767) begin
            scaled      = 32767;
            res.clipped = 1'b1;
        end else if (scaled < -32768) begin
            scaled      = -32768;
            res.clipped = 1'b1;
        end
        res.sample_out = scaled[15:0];
        if (model_cfg.mute) begin
            target    = 0;
            smooth_sh = SlopeBase - (model_cfg.slope_setting >> 1);
        end else begin
            target    = longint'(model_cfg.mant_setting) << GainShift;
            smooth_sh = SlopeBase - model_cfg.slope_setting;
        end
        g         = g + ((target - g) >>> smooth_sh);
        ramp_gain = g[31:0];
        return res;
    endfunction

    function automatic void add_sample(input logic [15:0] smp, input logic typed,
                                       input sample_result_t res);
        dir_rows.push_back('{RowSample, RegMantissa, {16'h0, smp}, typed, res});
    endfunction

    function automatic void add_write(input logic [1:0] idx, input logic [31:0] val);
        dir_rows.push_back('{RowWrite, idx, val, 1'b0, '0});
    endfunction

    // Offer one sample word; predict its result once it is taken
    task automatic offer_sample(input logic [15:0] smp, input logic typed,
                                input sample_result_t typed_res);
        sample_result_t pred;
        while (!(n_sent >= QuietLo && n_sent < QuietHi) && $urandom_range(99) < IdlePct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        pred = scale_and_ramp(smp);
        scaled_q.push_back(typed ? typed_res : pred);
        n_sent++;
    endtask

    // Stop offering and let every word in flight come out
    task automatic settle_pipe();
        s_tvalid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge aclk);
        repeat (PipeDepth + 2) @(posedge aclk);
    endtask

    // Setup and access cycle, then the bus goes idle
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegMantissa: model_cfg.mant_setting  = val[7:0];
            RegExponent: model_cfg.exp_setting   = val[3:0];
            RegSlope:    model_cfg.slope_setting = val[3:0];
            RegMute:     model_cfg.mute          = val[0];
            default: ;
        endcase
        n_writes++;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        logic [15:0] smp;
        case ($urandom_range(9))
            0: smp = 16'h7FFF;
            1: smp = 16'h8000;
            2: smp = 16'($signed($urandom_range(512)) - 256);
            default: smp = $urandom();
        endcase
        return smp;
    endfunction

    function automatic logic [31:0] pick_field(input int hi);
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = 0;
            1: v = hi;
            default: v = $urandom_range(hi);
        endcase
        // upper bits must be dropped by the register
        if ($urandom_range(3) == 0) v = v | ($urandom() & ~32'(hi));
        return v;
    endfunction

    // Sink: check each output word, then pick tready for the next edge
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (scaled_q.size() == 0) begin
                err_cnt++;
                $error("unexpected output word: sample_out %h clipped %b", m_tdata, m_tuser[0]);
            end else begin
                got_want = scaled_q.pop_front();
                if (m_tdata !== got_want.sample_out) begin
                    err_cnt++;
                    $error("sample_out: expected %h, actual %h", got_want.sample_out, m_tdata);
                end
                if (m_tuser[0] !== got_want.clipped) begin
                    err_cnt++;
                    $error("clipped: expected %b, actual %b", got_want.clipped, m_tuser[0]);
                end
            end
            if (m_tuser[0] === 1'b1) n_clip++;
            n_recv++;
            if (n_recv == HoldAt) hold_left = HoldLen;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (n_recv >= QuietLo && n_recv < QuietHi) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IdlePct);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("soft_mute_gain_ramp_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n_items;
        // Gain starts at zero, so the first word is silent; the next sees one ramp step
        add_sample(16'h7FFF, 1'b1, '{16'h0000, 1'b0});
        add_sample(16'h8000, 1'b1, '{16'hFF80, 1'b0});
        add_sample(16'h0001, 1'b0, '0);
        // Full target, base shift only, fastest ramp; junk in upper bits
        add_write(RegMantissa, 32'hFFFF_FFFF);
        add_write(RegExponent, 32'h0000_0000);
        add_write(RegSlope,    32'hFFFF_FFFF);
        add_sample(16'h1234, 1'b0, '0);
        add_sample(16'h7FFF, 1'b1, '{16'h7FFF, 1'b1});
        add_sample(16'h8000, 1'b1, '{16'h8000, 1'b1});
        add_sample(16'h0000, 1'b1, '{16'h0000, 1'b0});
        add_sample(16'hFFFF, 1'b0, '0);
        add_sample(16'h0040, 1'b0, '0);
        // Mute with an odd slope, then the largest post shift
        add_write(RegMute, 32'h0000_0001);
        add_sample(16'h4000, 1'b0, '0);
        add_sample(16'hC000, 1'b0, '0);
        add_write(RegExponent, 32'h0000_000F);
        add_sample(16'h7FFF, 1'b0, '0);
        add_sample(16'h8000, 1'b0, '0);
        // Unmute toward a zero target at the slowest slope
        add_write(RegMute, 32'h0000_0000);
        add_write(RegSlope, 32'h0000_0000);
        add_write(RegMantissa, 32'h0000_0000);
        add_write(RegExponent, 32'h0000_0002);
        add_sample(16'h5555, 1'b0, '0);
        add_sample(16'hAAAA, 1'b0, '0);
        // Target change in the middle of a ramp
        add_write(RegSlope, 32'h0000_000C);
        add_write(RegMantissa, 32'h0000_00C0);
        add_sample(16'h2000, 1'b0, '0);
        add_sample(16'hE000, 1'b0, '0);
        add_write(RegMantissa, 32'h0000_0010);
        add_sample(16'h7FFF, 1'b0, '0);
        add_sample(16'h8001, 1'b0, '0);

        // Hold reset, then load the model's power-on state
        repeat (ResetLen) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        model_cfg = '{8'd128, 4'd5, 4'd8, 1'b0};
        ramp_gain = '0;

        // Directed rows
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == RowWrite) begin
                settle_pipe();
                apb_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                offer_sample(dir_rows[i].value[15:0], dir_rows[i].typed,
                             dir_rows[i].typed_res);
            end
        end

        // Random phases: new register settings, then a burst of samples
        for (int p = 0; p < PhaseCount; p++) begin
            settle_pipe();
            apb_write(RegMantissa, pick_field(255));
            apb_write(RegExponent, pick_field(15));
            apb_write(RegSlope, ($urandom_range(2) == 0) ? pick_field(15)
                                                          : 32'($urandom_range(15, 8)));
            apb_write(RegMute, ($urandom_range(9) < 3) ? 32'd1 : 32'd0);
            n_items = $urandom_range(120, 90);
            repeat (n_items) offer_sample(pick_sample(), 1'b0, '0);
        end

        // Drain and let any stray words surface
        s_tvalid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge aclk);
        repeat (4 * PipeDepth) @(posedge aclk);

        $display("run covered %0d samples in, %0d words out (%0d clipped), %0d register writes",
                 n_sent, n_recv, n_clip, n_writes);
        $display("with a long sink hold-off, mute ramps and extreme gain settings");
        if (err_cnt == 0) begin
            $display("soft_mute_gain_ramp_top: match");
        end else begin
            $display("soft_mute_gain_ramp_top: mismatch");
        end
        $finish;
    end

endmodule
